@@ src/itbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_pkg
// Shared types, widths and character codes of the radix text converter.
// ----------------------------------------------------------------------------
package itbd_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int BASE_W      = 6;
  localparam int DIGIT_W     = BASE_W;
  localparam int CHAR_W      = 7;
  localparam int IDX_W       = $clog2(NUMBER_BITS);
  localparam int CNT_W       = $clog2(NUMBER_BITS + 1);
  localparam int BIT_W       = $clog2(NUMBER_BITS);

  localparam logic [BASE_W-1:0]  BASE_MIN      = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX      = BASE_W'(36);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = DIGIT_W'(9);
  localparam logic [CHAR_W-1:0]  DEC_DIGITS    = CHAR_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = CHAR_W'(65);
  localparam logic [CHAR_W-1:0]  CHAR_MINUS    = CHAR_W'(45);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } itbd_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d > DIGIT_MAX_DEC) begin
      return d_ext - DEC_DIGITS + CHAR_LETTER_A;
    end
    return d_ext + CHAR_ZERO;
  endfunction

endpackage

@@ src/itbd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd channel interfaces
// Request channel (number, base) and character channel (text_char, last).
// ----------------------------------------------------------------------------
interface itbd_num_if import itbd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [NUMBER_BITS-1:0] number;
  logic        [BASE_W-1:0]      base;

  modport source (output valid, number, base, input ready);
  modport sink   (input valid, number, base, output ready);
endinterface

interface itbd_char_if import itbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last;

  modport source (output valid, text_char, last, input ready);
  modport sink   (input valid, text_char, last, output ready);
endinterface

@@ src/integer_to_base_digits_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_base_digits_top
// Converts a signed integer to ASCII text in base 2..36, one character per
// output request, most significant first, with '-' for negative numbers.
// ----------------------------------------------------------------------------
//  channel  dir  payload                   notes
//  num_i    in   number[31:0], base[5:0]   taken only when idle
//  char_o   out  text_char[6:0], last      registered, last on final char
//
//  One restoring divider step per cycle; each digit takes a full pass over
//  the dividend bits. Each character is then read from the digit store and
//  loaded into the output register, after a '-' for a negative number.
//  Reset clears the sequencer and output valid; the digit store is not cleared.
//  A stalled output holds its character and the sequencer waits on it.
module integer_to_base_digits_top import itbd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  itbd_num_if.sink       num_i,
  itbd_char_if.source    char_o
);

  itbd_state_e state_q, state_d;

  logic [NUMBER_BITS-1:0] rest_q;
  logic [DIGIT_W-1:0]     rem_q;
  logic [BASE_W-1:0]      base_q;
  logic [BIT_W-1:0]       bit_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   neg_q;
  logic [IDX_W-1:0]       idx_q;
  logic [DIGIT_W-1:0]     rd_q;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      out_char_q;
  logic                   out_last_q;

  logic [DIGIT_W-1:0]     digit_mem [NUMBER_BITS];

  // control
  logic accept, div_step, digit_end, div_done, load_sign, load_digit, rd_en;
  logic out_free;

  // datapath
  logic [NUMBER_BITS-1:0] num_u, mag;
  logic [BASE_W-1:0]      base_clamp;
  logic [DIGIT_W:0]       rem_shift, rem_sub;
  logic                   fit;
  logic [DIGIT_W-1:0]     rem_next;
  logic [NUMBER_BITS-1:0] quot_next;
  logic [CNT_W-1:0]       cnt_inc;

  assign num_u = num_i.number;
  assign mag   = num_u[NUMBER_BITS-1] ? (~num_u + 1'b1) : num_u;

  always_comb begin
    if (num_i.base < BASE_MIN) begin
      base_clamp = BASE_MIN;
    end else if (num_i.base > BASE_MAX) begin
      base_clamp = BASE_MAX;
    end else begin
      base_clamp = num_i.base;
    end
  end

  // shared divider step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_q, rest_q[NUMBER_BITS-1]};
  assign rem_sub   = rem_shift - {1'b0, base_q};
  assign fit       = rem_shift >= {1'b0, base_q};
  assign rem_next  = fit ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
  assign quot_next = {rest_q[NUMBER_BITS-2:0], fit};
  assign cnt_inc   = cnt_q + 1'b1;

  assign out_free  = !out_valid_q || char_o.ready;

  // outputs of the sequencer
  always_comb begin
    accept      = 1'b0;
    div_step    = 1'b0;
    digit_end   = 1'b0;
    div_done    = 1'b0;
    load_sign   = 1'b0;
    load_digit  = 1'b0;
    rd_en       = 1'b0;
    num_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        num_i.ready = 1'b1;
        accept      = num_i.valid;
      end
      ST_DIV: begin
        div_step  = 1'b1;
        digit_end = (bit_q == BIT_W'(NUMBER_BITS - 1));
        div_done  = digit_end &&
                    ((quot_next == '0) || (cnt_inc == CNT_W'(NUMBER_BITS)));
      end
      ST_SIGN: load_sign  = out_free;
      ST_READ: rd_en      = 1'b1;
      ST_LOAD: load_digit = out_free;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = neg_q ? ST_SIGN : ST_READ;
      end
      ST_SIGN: if (load_sign) state_d = ST_READ;
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: begin
        if (load_digit) state_d = (idx_q == '0) ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        bit_q <= '0;
        cnt_q <= '0;
        neg_q <= num_u[NUMBER_BITS-1];
      end else if (div_step) begin
        bit_q <= bit_q + 1'b1;
        if (digit_end) begin
          cnt_q <= cnt_inc;
          idx_q <= cnt_q[IDX_W-1:0];
        end
      end else if (load_digit) begin
        idx_q <= idx_q - 1'b1;
      end
      if (load_sign || load_digit) begin
        out_valid_q <= 1'b1;
      end else if (char_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rest_q <= mag;
      rem_q  <= '0;
      base_q <= base_clamp;
    end else if (div_step) begin
      rest_q <= quot_next;
      // start the next digit with an empty remainder
      rem_q  <= digit_end ? '0 : rem_next;
    end
    if (load_sign) begin
      out_char_q <= CHAR_MINUS;
      out_last_q <= 1'b0;
    end else if (load_digit) begin
      out_char_q <= digit_char(rd_q);
      out_last_q <= (idx_q == '0);
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (div_step && digit_end) begin
      digit_mem[cnt_q[IDX_W-1:0]] <= rem_next;
    end
    if (rd_en) begin
      rd_q <= digit_mem[idx_q];
    end
  end

  assign char_o.valid     = out_valid_q;
  assign char_o.text_char = out_char_q;
  assign char_o.last      = out_last_q;

`ifndef NO_ASSERTIONS
  a_last_not_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid && char_o.last |-> char_o.text_char != CHAR_MINUS)
    else $error("final character is a minus sign");

  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < base_q)
    else $error("divider remainder not below base");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUMBER_BITS))
    else $error("digit count beyond store depth");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_i.valid && num_i.ready |=> state_q == ST_DIV && bit_q == '0)
    else $error("request did not start a division");
`endif

endmodule
